// ===== hw/rtl/fexp_pkg.sv =====
// ----------------------------------------------------------------------------
// fexp_pkg
// Shared constants, types and fp32 helper functions for the fast exponential.
// ----------------------------------------------------------------------------
package fexp_pkg;

    localparam logic [31:0] SCALE_RESET  = 32'h4B38AA3B;
    localparam logic [31:0] OFFSET_RESET = 32'd1064866360;
    localparam logic [31:0] QUIET_BIT    = 32'h00400000;
    localparam logic [31:0] CANON_NAN    = 32'h7FC00000;

    localparam logic REG_SCALE  = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    // unpacked operand: value = m * 2^(e-23), m[23] set for nonzero finite
    typedef struct packed {
        logic              sgn;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [9:0] e;
        logic [23:0]       m;
    } fp_unp_t;

    typedef struct packed {
        logic [31:0] ival;
        logic        flag;
    } fp_int_t;

    // x / 2 with round to nearest even when the half is subnormal
    function automatic logic [31:0] fp_halve(input logic [31:0] b);
        logic [7:0]  ex;
        logic [23:0] s;
        logic        up;
        logic [31:0] r;
        ex = b[30:23];
        s  = {(ex == 8'd1), b[22:0]};
        up = s[0] & s[1];
        if (ex == 8'hFF)
            r = b;
        else if (ex >= 8'd2)
            r = {b[31], ex - 8'd1, b[22:0]};
        else
            r = {b[31], 31'({8'b0, s[23:1]}) + 31'(up)};
        return r;
    endfunction

    function automatic fp_unp_t fp_unpack(input logic [31:0] b);
        fp_unp_t     u;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [4:0]  lz;
        logic        found;
        ex = b[30:23];
        fr = b[22:0];
        lz = 5'd0;
        found = 1'b0;
        for (int i = 22; i >= 0; i--) begin
            if (!found && fr[i]) begin
                lz = 5'(22 - i);
                found = 1'b1;
            end
        end
        u.sgn  = b[31];
        u.nan  = (ex == 8'hFF) && (fr != 23'd0);
        u.inf  = (ex == 8'hFF) && (fr == 23'd0);
        u.zero = (ex == 8'd0) && (fr == 23'd0);
        if (ex != 8'd0) begin
            u.e = $signed({2'b00, ex}) - 10'sd127;
            u.m = {1'b1, fr};
        end
        else begin
            u.e = -10'sd127 - $signed({5'b00000, lz});
            u.m = {fr, 1'b0} << lz;
        end
        return u;
    endfunction

    // round a 48-bit significand product to fp32, nearest even
    function automatic logic [31:0] fp_round(
        input logic              sgn,
        input logic              nan,
        input logic              inf,
        input logic              zero,
        input logic signed [10:0] e,
        input logic [47:0]       p
    );
        logic signed [10:0] ee;
        logic signed [10:0] be;
        logic signed [10:0] s;
        logic [47:0]        sig;
        logic [47:0]        sh_sig;
        logic [5:0]         shc;
        logic               lost;
        logic [7:0]         expf;
        logic [23:0]        kept;
        logic               rnd;
        logic               st;
        logic               up;
        logic [30:0]        body;
        logic [31:0]        r;
        if (p[47]) begin
            ee  = e + 11'sd1;
            sig = p;
        end
        else begin
            ee  = e;
            sig = p << 1;
        end
        be = ee + 11'sd127;
        s  = 11'sd1 - be;
        if (be >= 11'sd1) begin
            shc    = 6'd0;
            sh_sig = sig;
            lost   = 1'b0;
            expf   = be[7:0];
        end
        else begin
            shc    = (s > 11'sd48) ? 6'd48 : s[5:0];
            sh_sig = sig >> shc;
            lost   = ((sh_sig << shc) != sig);
            expf   = 8'd0;
        end
        kept = sh_sig[47:24];
        rnd  = sh_sig[23];
        st   = (sh_sig[22:0] != 23'd0) | lost;
        up   = rnd & (st | kept[0]);
        body = {expf, kept[22:0]} + 31'(up);
        if (nan)
            r = CANON_NAN;
        else if (inf || be >= 11'sd255)
            r = {sgn, 8'hFF, 23'd0};
        else if (zero)
            r = {sgn, 31'd0};
        else
            r = {sgn, body};
        return r;
    endfunction

    // truncate toward zero to int32, clamp and flag
    function automatic fp_int_t fp_to_int(input logic [31:0] b);
        fp_int_t     t;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [31:0] mag;
        ex  = b[30:23];
        fr  = b[22:0];
        mag = 32'd0;
        t.flag = 1'b0;
        t.ival = 32'd0;
        if ((ex == 8'hFF) && (fr != 23'd0)) begin
            t.flag = 1'b1;
        end
        else if (ex >= 8'd158) begin
            if (b[31]) begin
                t.ival = 32'h80000000;
                t.flag = !((ex == 8'd158) && (fr == 23'd0));
            end
            else begin
                t.ival = 32'h7FFFFFFF;
                t.flag = 1'b1;
            end
        end
        else if (ex >= 8'd127) begin
            if (ex >= 8'd150)
                mag = {8'd0, 1'b1, fr} << (ex - 8'd150);
            else
                mag = {8'd0, 1'b1, fr} >> (8'd150 - ex);
            t.ival = b[31] ? (32'd0 - mag) : mag;
        end
        return t;
    endfunction

endpackage

// ===== hw/rtl/fexp_fmul.sv =====
// ----------------------------------------------------------------------------
// fexp_fmul
// Three-stage fp32 multiplier (unpack, multiply, round) with a sideband
// that travels alongside each operand pair.
// ----------------------------------------------------------------------------
module fexp_fmul
    import fexp_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic [2:0]        en,
    input  logic [31:0]       a_bits,
    input  logic [31:0]       b_bits,
    input  logic [SIDE_W-1:0] side_in,
    output logic [31:0]       prod_bits,
    output logic [SIDE_W-1:0] side_out
);

    fp_unp_t            ua_reg;
    fp_unp_t            ub_reg;
    logic [SIDE_W-1:0]  side1_reg;
    logic               sgn_reg;
    logic               nan_reg;
    logic               inf_reg;
    logic               zero_reg;
    logic signed [10:0] e_reg;
    logic [47:0]        p_reg;
    logic [SIDE_W-1:0]  side2_reg;
    logic [31:0]        bits_reg;
    logic [SIDE_W-1:0]  side3_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ua_reg    <= fp_unpack(a_bits);
            ub_reg    <= fp_unpack(b_bits);
            side1_reg <= side_in;
        end
        if (en[1])
        begin
            sgn_reg   <= ua_reg.sgn ^ ub_reg.sgn;
            nan_reg   <= ua_reg.nan | ub_reg.nan | (ua_reg.inf & ub_reg.zero)
                         | (ua_reg.zero & ub_reg.inf);
            inf_reg   <= ua_reg.inf | ub_reg.inf;
            zero_reg  <= ua_reg.zero | ub_reg.zero;
            e_reg     <= 11'(ua_reg.e) + 11'(ub_reg.e);
            p_reg     <= 48'(ua_reg.m) * 48'(ub_reg.m);
            side2_reg <= side1_reg;
        end
        if (en[2])
        begin
            bits_reg  <= fp_round(sgn_reg, nan_reg, inf_reg, zero_reg, e_reg, p_reg);
            side3_reg <= side2_reg;
        end
    end

    assign prod_bits = bits_reg;
    assign side_out  = side3_reg;

endmodule

// ===== hw/rtl/fast_exp_bit_trick.sv =====
// ----------------------------------------------------------------------------
// fast_exp_bit_trick
// Approximate fp32 exponential by the exponent-field bit trick.
//
// Input channel: in_valid/in_ready with mode and value_bits. Output channel:
// out_valid/out_ready with result_bits and out_of_range. Configuration
// channel: cfg_valid/cfg_ready with cfg_index (0 scale, 1 offset) and
// cfg_data; cfg_ready is always high, write only while the block is idle.
// One item is taken every cycle while in_ready is high; the depth is set
// by the two three-stage fp32 multipliers plus the halving, integer
// conversion and output stages.
// Reset clears all valid bits and loads the default scale and offset.
// When the receiver stalls, items pack into empty stages behind the output
// register; in_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module fast_exp_bit_trick
    import fexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits,
    output logic        out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SIDE2_W = 35;

    logic [31:0]        scale_reg;
    logic [31:0]        offset_reg;
    logic [9:1]         v_reg;
    logic [9:1]         en;

    logic [31:0]        h_reg;
    logic               mode1_reg;
    logic [31:0]        prod1;
    logic               mode4;
    fp_int_t            ti;
    logic [31:0]        a_reg;
    logic               flag5_reg;
    logic               mode5_reg;
    logic               a_nan;
    logic [31:0]        sq;
    logic [SIDE2_W-1:0] side8;
    logic [31:0]        res_reg;
    logic               flag9_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCALE:  scale_reg  <= cfg_data;
                REG_OFFSET: offset_reg <= cfg_data;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its item moves on
    always_comb
    begin
        en[9] = !v_reg[9] || out_ready;
        for (int k = 8; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[1])
                v_reg[1] <= in_valid;
            for (int k = 2; k <= 9; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // halve for mode 1
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h_reg     <= mode ? fp_halve(value_bits) : value_bits;
            mode1_reg <= mode;
        end
    end

    fexp_fmul #(.SIDE_W(1)) u_scale_mul (
        .clk      (clk),
        .en       (en[4:2]),
        .a_bits   (h_reg),
        .b_bits   (scale_reg),
        .side_in  (mode1_reg),
        .prod_bits(prod1),
        .side_out (mode4)
    );

    // truncate to int32 and add offset
    assign ti = fp_to_int(prod1);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            a_reg     <= ti.ival + offset_reg;
            flag5_reg <= ti.flag;
            mode5_reg <= mode4;
        end
    end

    assign a_nan = (a_reg[30:23] == 8'hFF) && (a_reg[22:0] != 23'd0);

    fexp_fmul #(.SIDE_W(SIDE2_W)) u_square_mul (
        .clk      (clk),
        .en       (en[8:6]),
        .a_bits   (a_reg),
        .b_bits   (a_reg),
        .side_in  ({mode5_reg, flag5_reg, a_nan, a_reg}),
        .prod_bits(sq),
        .side_out (side8)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            if (!side8[34])
                res_reg <= side8[31:0];
            else if (side8[32])
                res_reg <= side8[31:0] | QUIET_BIT;
            else
                res_reg <= sq;
            flag9_reg <= side8[33];
        end
    end

    assign out_valid    = v_reg[9];
    assign result_bits  = res_reg;
    assign out_of_range = flag9_reg;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input refused without an output stall");

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[9] && !out_ready && v_reg[8]) |=> (v_reg[9] && v_reg[8]))
        else $error("item lost behind stalled output");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !out_ready) |-> !in_ready)
        else $error("full pipeline accepted an item");

endmodule
